// File: rtl/spc_pkg.sv
// Shared types and constants for the station presence checker.
package spc_pkg;

  typedef enum logic [2:0] {
    PH_ABSENT  = 3'd0,
    PH_PRESENT = 3'd1,
    PH_INIT    = 3'd2,
    PH_SETTLE  = 3'd3,
    PH_LEVEL   = 3'd4,
    PH_QUALITY = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    HINT_NONE           = 2'd0,
    HINT_LEVEL_SETTLE   = 2'd1,
    HINT_INTERVAL       = 2'd2,
    HINT_QUALITY_SETTLE = 2'd3
  } hint_t;

  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_POLL  = 1'b1
  } req_t;

  // Register indexes, byte address is 4 * index
  localparam logic [2:0] REG_HIGH_SENS    = 3'd0;
  localparam logic [2:0] REG_FM_LVL_NORM  = 3'd1;
  localparam logic [2:0] REG_FM_LVL_STR   = 3'd2;
  localparam logic [2:0] REG_AM_LVL_NORM  = 3'd3;
  localparam logic [2:0] REG_AM_LVL_STR   = 3'd4;
  localparam logic [2:0] REG_FM_NOISE     = 3'd5;
  localparam logic [2:0] REG_FM_MULTIPATH = 3'd6;

  localparam logic signed [11:0] FM_LVL_NORM_RST = 12'sd200;
  localparam logic signed [11:0] FM_LVL_STR_RST  = 12'sd300;
  localparam logic signed [11:0] AM_LVL_NORM_RST = 12'sd300;
  localparam logic signed [11:0] AM_LVL_STR_RST  = 12'sd400;
  localparam logic [6:0]         FM_NOISE_RST    = 7'd30;
  localparam logic [6:0]         FM_MPATH_RST    = 7'd30;

  // Offset limits in 0.1 kHz, compared against the offset magnitude
  localparam logic [11:0] FM_OFFSET_LIMIT = 12'd100;
  localparam logic [11:0] AM_OFFSET_LIMIT = 12'd50;

  localparam logic [1:0] FM_CHECKS = 2'd2;
  localparam logic [1:0] AM_CHECKS = 2'd3;
  localparam logic [1:0] PASS_MAX  = 2'd3;

endpackage

// File: rtl/station_presence_checker.sv
// Station presence checker: top level with input stage, step logic and result register.
//
// Usage: a start beat (req_type 0) arms the checker; each poll beat (req_type 1)
// advances it one step: init, settle, level checks (two on FM, three on AM),
// then the quality check. Every input beat yields exactly one result beat with
// the phase reached (status), the level checks passed (checks_done) and the wait
// to observe before the next poll (wait_hint).
// Channels: in_valid/in_ready carry the measurement fields, out_valid/out_ready carry
// the result. Thresholds and limits sit in APB registers at 4*index; the user must
// write them only while no beat is in flight (no hardware guard); pready is tied high.
// Path: a beat moves from the input register into the result register.
// Throughput: one beat per cycle while out_ready is high; the phase update is a
// single compare-and-select step done as the beat moves into the result register.
// Stall: while out_ready is low the result holds and one more beat can wait in
// the input register; after that in_ready drops.
// Reset: synchronous, clears both stages, sets the phase to absent with zero
// passes and loads the default thresholds.
module station_presence_checker (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic               is_fm,
  input  logic signed [11:0] level,
  input  logic               level_valid,
  input  logic        [6:0]  noise,
  input  logic        [6:0]  multipath,
  input  logic signed [11:0] freq_offset,
  input  logic               quality_valid,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [2:0]  status,
  output logic        [1:0]  checks_done,
  output logic        [1:0]  wait_hint,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  // configuration registers
  logic               high_sensitivity;
  logic signed [11:0] fm_level_normal;
  logic signed [11:0] fm_level_strict;
  logic signed [11:0] am_level_normal;
  logic signed [11:0] am_level_strict;
  logic        [6:0]  fm_noise_limit;
  logic        [6:0]  fm_multipath_limit;

  // input stage
  logic               s1_valid;
  logic               s1_req;
  logic               s1_is_fm;
  logic signed [11:0] s1_level;
  logic               s1_level_valid;
  logic        [6:0]  s1_noise;
  logic        [6:0]  s1_multipath;
  logic signed [11:0] s1_freq_offset;
  logic               s1_quality_valid;

  // checker state
  spc_pkg::phase_t    phase;
  logic        [1:0]  passes;

  spc_pkg::phase_t    phase_next;
  logic        [1:0]  passes_next;
  spc_pkg::hint_t     hint_next;

  logic               out_load;
  logic               cfg_wr;
  logic        [2:0]  reg_idx;
  logic signed [11:0] level_thr;
  logic        [11:0] offset_mag;
  logic        [1:0]  checks_needed;
  logic        [1:0]  passes_inc;
  logic               quality_good;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;

  always_comb begin
    case (reg_idx)
      spc_pkg::REG_HIGH_SENS:    prdata = {31'd0, high_sensitivity};
      spc_pkg::REG_FM_LVL_NORM:  prdata = {20'd0, fm_level_normal};
      spc_pkg::REG_FM_LVL_STR:   prdata = {20'd0, fm_level_strict};
      spc_pkg::REG_AM_LVL_NORM:  prdata = {20'd0, am_level_normal};
      spc_pkg::REG_AM_LVL_STR:   prdata = {20'd0, am_level_strict};
      spc_pkg::REG_FM_NOISE:     prdata = {25'd0, fm_noise_limit};
      spc_pkg::REG_FM_MULTIPATH: prdata = {25'd0, fm_multipath_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  // step logic
  always_comb begin
    if (s1_is_fm) begin
      level_thr     = high_sensitivity ? fm_level_strict : fm_level_normal;
      checks_needed = spc_pkg::FM_CHECKS;
    end else begin
      level_thr     = high_sensitivity ? am_level_strict : am_level_normal;
      checks_needed = spc_pkg::AM_CHECKS;
    end
    // magnitude of the most negative code still fits 12 bits unsigned
    offset_mag = s1_freq_offset[11] ? 12'(-s1_freq_offset) : 12'(s1_freq_offset);
    if (s1_is_fm) begin
      quality_good = (s1_noise < fm_noise_limit) && (s1_multipath < fm_multipath_limit) &&
                     (offset_mag < spc_pkg::FM_OFFSET_LIMIT);
    end else begin
      quality_good = offset_mag < spc_pkg::AM_OFFSET_LIMIT;
    end
    passes_inc = (passes == spc_pkg::PASS_MAX) ? passes : passes + 2'd1;

    phase_next  = phase;
    passes_next = passes;
    hint_next   = spc_pkg::HINT_NONE;
    if (s1_req == spc_pkg::REQ_START) begin
      phase_next  = spc_pkg::PH_INIT;
      passes_next = 2'd0;
    end else begin
      case (phase)
        spc_pkg::PH_INIT: begin
          phase_next = spc_pkg::PH_SETTLE;
        end
        spc_pkg::PH_SETTLE: begin
          phase_next  = spc_pkg::PH_LEVEL;
          passes_next = 2'd0;
          hint_next   = spc_pkg::HINT_LEVEL_SETTLE;
        end
        spc_pkg::PH_LEVEL: begin
          if (!s1_level_valid || (s1_level < level_thr)) begin
            phase_next = spc_pkg::PH_ABSENT;
          end else begin
            passes_next = passes_inc;
            if (passes_inc >= checks_needed) begin
              phase_next = spc_pkg::PH_QUALITY;
              hint_next  = spc_pkg::HINT_QUALITY_SETTLE;
            end else begin
              hint_next = spc_pkg::HINT_INTERVAL;
            end
          end
        end
        spc_pkg::PH_QUALITY: begin
          phase_next = (s1_quality_valid && quality_good) ? spc_pkg::PH_PRESENT
                                                          : spc_pkg::PH_ABSENT;
        end
        spc_pkg::PH_ABSENT, spc_pkg::PH_PRESENT: begin
          phase_next = phase;
        end
        default: begin
          phase_next = spc_pkg::PH_ABSENT;
        end
      endcase
    end
  end

  // control state, result register and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      out_valid          <= 1'b0;
      phase              <= spc_pkg::PH_ABSENT;
      passes             <= 2'd0;
      status             <= spc_pkg::PH_ABSENT;
      checks_done        <= 2'd0;
      wait_hint          <= spc_pkg::HINT_NONE;
      high_sensitivity   <= 1'b0;
      fm_level_normal    <= spc_pkg::FM_LVL_NORM_RST;
      fm_level_strict    <= spc_pkg::FM_LVL_STR_RST;
      am_level_normal    <= spc_pkg::AM_LVL_NORM_RST;
      am_level_strict    <= spc_pkg::AM_LVL_STR_RST;
      fm_noise_limit     <= spc_pkg::FM_NOISE_RST;
      fm_multipath_limit <= spc_pkg::FM_MPATH_RST;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid   <= 1'b1;
        phase       <= phase_next;
        passes      <= passes_next;
        status      <= phase_next;
        checks_done <= passes_next;
        wait_hint   <= hint_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        case (reg_idx)
          spc_pkg::REG_HIGH_SENS:    high_sensitivity   <= pwdata[0];
          spc_pkg::REG_FM_LVL_NORM:  fm_level_normal    <= pwdata[11:0];
          spc_pkg::REG_FM_LVL_STR:   fm_level_strict    <= pwdata[11:0];
          spc_pkg::REG_AM_LVL_NORM:  am_level_normal    <= pwdata[11:0];
          spc_pkg::REG_AM_LVL_STR:   am_level_strict    <= pwdata[11:0];
          spc_pkg::REG_FM_NOISE:     fm_noise_limit     <= pwdata[6:0];
          spc_pkg::REG_FM_MULTIPATH: fm_multipath_limit <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req           <= req_type;
      s1_is_fm         <= is_fm;
      s1_level         <= level;
      s1_level_valid   <= level_valid;
      s1_noise         <= noise;
      s1_multipath     <= multipath;
      s1_freq_offset   <= freq_offset;
      s1_quality_valid <= quality_valid;
    end
  end

  // a result beat always matches the state it left behind
  a_status_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == phase))
    else $error("result status differs from checker phase");

  a_quality_hint: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (wait_hint == spc_pkg::HINT_QUALITY_SETTLE)) |->
      (status == spc_pkg::PH_QUALITY && checks_done != 2'd0))
    else $error("quality settle hint outside quality check");

  a_interval_hint: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (wait_hint == spc_pkg::HINT_INTERVAL)) |->
      (status == spc_pkg::PH_LEVEL && checks_done != 2'd0))
    else $error("check interval hint without a passed level check");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");

endmodule

// File: tb/testbench.sv
// Testbench for the station presence checker: directed table, random sequences, self-checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE   = 3'd7;   // beyond the register list, writes ignored
  localparam int         NUM_PHASES  = 6;
  localparam int         PHASE_BEATS = 275;
  localparam int         CYCLE_LIMIT = 500000;

  typedef struct {
    spc_pkg::req_t      req;
    logic               fm;
    logic signed [11:0] level;
    logic               level_ok;
    logic        [6:0]  noise;
    logic        [6:0]  mpath;
    logic signed [11:0] offset;
    logic               quality_ok;
  } stim_t;

  typedef struct packed {
    logic [2:0]     status;
    logic [1:0]     checks;
    spc_pkg::hint_t hint;
  } result_t;

  typedef struct {
    stim_t   s;
    bit      fixed;
    result_t want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               req_type;
  logic               is_fm;
  logic signed [11:0] level;
  logic               level_valid;
  logic        [6:0]  noise;
  logic        [6:0]  multipath;
  logic signed [11:0] freq_offset;
  logic               quality_valid;
  logic               out_valid;
  logic               out_ready;
  logic        [2:0]  status;
  logic        [1:0]  checks_done;
  logic        [1:0]  wait_hint;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [4:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;

  station_presence_checker dut (.*);

  // predictor copy of the registers and state
  logic               strict_mode;
  logic signed [11:0] fm_thr_normal, fm_thr_strict, am_thr_normal, am_thr_strict;
  logic        [6:0]  noise_lim, mpath_lim;
  spc_pkg::phase_t    phase;
  logic        [1:0]  passes;

  result_t presence_due[$];
  row_t    plan[$];
  int      mismatches;
  int      cycle_count;
  int      beats_sent;
  bit      sender_calm;
  bit      seq_fm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic result_t presence_step(input stim_t s);
    result_t            r;
    logic signed [11:0] thr;
    logic        [1:0]  need;
    int                 mag;
    logic               good;
    r.hint = spc_pkg::HINT_NONE;
    if (s.req == spc_pkg::REQ_START) begin
      phase  = spc_pkg::PH_INIT;
      passes = 2'd0;
    end else begin
      case (phase)
        spc_pkg::PH_INIT: phase = spc_pkg::PH_SETTLE;
        spc_pkg::PH_SETTLE: begin
          phase  = spc_pkg::PH_LEVEL;
          passes = 2'd0;
          r.hint = spc_pkg::HINT_LEVEL_SETTLE;
        end
        spc_pkg::PH_LEVEL: begin
          thr = s.fm ? (strict_mode ? fm_thr_strict : fm_thr_normal)
                     : (strict_mode ? am_thr_strict : am_thr_normal);
          if (!s.level_ok || s.level < thr) begin
            phase = spc_pkg::PH_ABSENT;
          end else begin
            if (passes != spc_pkg::PASS_MAX) passes = passes + 2'd1;
            // band is taken from this beat, so a switch can jump straight to quality
            need = s.fm ? spc_pkg::FM_CHECKS : spc_pkg::AM_CHECKS;
            if (passes >= need) begin
              phase  = spc_pkg::PH_QUALITY;
              r.hint = spc_pkg::HINT_QUALITY_SETTLE;
            end else begin
              r.hint = spc_pkg::HINT_INTERVAL;
            end
          end
        end
        spc_pkg::PH_QUALITY: begin
          mag = s.offset;
          if (mag < 0) mag = -mag;
          if (s.fm)
            good = s.noise < noise_lim && s.mpath < mpath_lim &&
                   mag < int'(spc_pkg::FM_OFFSET_LIMIT);
          else
            good = mag < int'(spc_pkg::AM_OFFSET_LIMIT);
          phase = (s.quality_ok && good) ? spc_pkg::PH_PRESENT : spc_pkg::PH_ABSENT;
        end
        spc_pkg::PH_ABSENT, spc_pkg::PH_PRESENT: ;
        default: phase = spc_pkg::PH_ABSENT;
      endcase
    end
    r.status = phase;
    r.checks = passes;
    return r;
  endfunction

  // mostly well-formed sequences: levels near the live threshold, quality near the limits
  function automatic stim_t draw_beat();
    stim_t s;
    int    thr;
    int    lvl;
    int    off;
    int    pick;
    if (phase == spc_pkg::PH_ABSENT || phase == spc_pkg::PH_PRESENT)
      s.req = ($urandom_range(0, 9) < 6) ? spc_pkg::REQ_START : spc_pkg::REQ_POLL;
    else
      s.req = ($urandom_range(0, 11) == 0) ? spc_pkg::REQ_START : spc_pkg::REQ_POLL;
    if (s.req == spc_pkg::REQ_START) seq_fm = 1'($urandom_range(0, 1));
    else if ($urandom_range(0, 19) == 0) seq_fm = !seq_fm;
    s.fm = seq_fm;
    thr = seq_fm ? (strict_mode ? fm_thr_strict : fm_thr_normal)
                 : (strict_mode ? am_thr_strict : am_thr_normal);
    pick = $urandom_range(0, 9);
    if (pick < 7) lvl = thr + int'($urandom_range(0, 300));
    else if (pick < 9) lvl = thr - int'($urandom_range(1, 200));
    else lvl = int'($urandom_range(0, 4095)) - 2048;
    if (lvl > 2047) lvl = 2047;
    if (lvl < -2048) lvl = -2048;
    s.level    = lvl[11:0];
    s.level_ok = $urandom_range(0, 19) != 0;
    s.noise = (noise_lim != 0 && $urandom_range(0, 4) != 0) ?
              7'($urandom_range(0, noise_lim - 1)) : 7'($urandom_range(0, 127));
    s.mpath = (mpath_lim != 0 && $urandom_range(0, 4) != 0) ?
              7'($urandom_range(0, mpath_lim - 1)) : 7'($urandom_range(0, 127));
    if ($urandom_range(0, 4) != 0)
      off = $urandom_range(0, (seq_fm ? spc_pkg::FM_OFFSET_LIMIT
                                      : spc_pkg::AM_OFFSET_LIMIT) - 1);
    else
      off = int'($urandom_range(0, 4095)) - 2048;
    if ($urandom_range(0, 1)) off = -off;
    s.offset     = off[11:0];
    s.quality_ok = $urandom_range(0, 11) != 0;
    return s;
  endfunction

  task automatic add_row(input spc_pkg::req_t rq, input int fm, input int lvl, input int lok,
                         input int nz, input int mp, input int off, input int qok,
                         input int fixed, input spc_pkg::phase_t st, input int chk,
                         input spc_pkg::hint_t h);
    row_t r;
    r.s.req        = rq;
    r.s.fm         = fm[0];
    r.s.level      = lvl[11:0];
    r.s.level_ok   = lok[0];
    r.s.noise      = nz[6:0];
    r.s.mpath      = mp[6:0];
    r.s.offset     = off[11:0];
    r.s.quality_ok = qok[0];
    r.fixed        = fixed[0];
    r.want.status  = st;
    r.want.checks  = chk[1:0];
    r.want.hint    = h;
    plan.push_back(r);
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input stim_t s, input bit fixed, input result_t want);
    int      gap;
    result_t predicted;
    if (beats_sent % 40 == 0) sender_calm = $urandom_range(0, 3) == 0;
    beats_sent++;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type      <= s.req;
    is_fm         <= s.fm;
    level         <= s.level;
    level_valid   <= s.level_ok;
    noise         <= s.noise;
    multipath     <= s.mpath;
    freq_offset   <= s.offset;
    quality_valid <= s.quality_ok;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = presence_step(s);
    presence_due.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (presence_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    case (idx)
      spc_pkg::REG_HIGH_SENS:    strict_mode   = val[0];
      spc_pkg::REG_FM_LVL_NORM:  fm_thr_normal = val[11:0];
      spc_pkg::REG_FM_LVL_STR:   fm_thr_strict = val[11:0];
      spc_pkg::REG_AM_LVL_NORM:  am_thr_normal = val[11:0];
      spc_pkg::REG_AM_LVL_STR:   am_thr_strict = val[11:0];
      spc_pkg::REG_FM_NOISE:     noise_lim     = val[6:0];
      spc_pkg::REG_FM_MULTIPATH: mpath_lim     = val[6:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int hs, input int fmn, input int fms, input int amn,
                           input int ams, input int nz, input int mp);
    set_reg(spc_pkg::REG_HIGH_SENS, hs);
    set_reg(spc_pkg::REG_FM_LVL_NORM, fmn);
    set_reg(spc_pkg::REG_FM_LVL_STR, fms);
    set_reg(spc_pkg::REG_AM_LVL_NORM, amn);
    set_reg(spc_pkg::REG_AM_LVL_STR, ams);
    set_reg(spc_pkg::REG_FM_NOISE, nz);
    set_reg(spc_pkg::REG_FM_MULTIPATH, mp);
  endtask

  task automatic flag_mismatch(input result_t want, input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected status %0d checks %0d hint %0d, got %0d %0d %0d",
               $realtime, what, want.status, want.checks, want.hint,
               status, checks_done, wait_hint);
  endtask

  // result side: random back-pressure, each taken beat checked against the oldest expectation
  initial begin : result_side
    int      gap;
    int      taken;
    bit      calm;
    result_t want;
    taken = 0;
    calm  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 40 == 0) calm = $urandom_range(0, 3) == 0;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (presence_due.size() == 0) begin
        want = '0;
        flag_mismatch(want, "result beat with nothing pending");
      end else begin
        want = presence_due.pop_front();
        if (status !== want.status || checks_done !== want.checks ||
            wait_hint !== want.hint)
          flag_mismatch(want, "result mismatch");
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    result_t no_fixed;
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = 1'b0;
    is_fm         = 1'b0;
    level         = '0;
    level_valid   = 1'b0;
    noise         = '0;
    multipath     = '0;
    freq_offset   = '0;
    quality_valid = 1'b0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_fixed      = '0;
    mismatches    = 0;
    beats_sent    = 0;
    sender_calm   = 1'b0;
    seq_fm        = 1'b1;
    strict_mode   = 1'b0;
    fm_thr_normal = spc_pkg::FM_LVL_NORM_RST;
    fm_thr_strict = spc_pkg::FM_LVL_STR_RST;
    am_thr_normal = spc_pkg::AM_LVL_NORM_RST;
    am_thr_strict = spc_pkg::AM_LVL_STR_RST;
    noise_lim     = spc_pkg::FM_NOISE_RST;
    mpath_lim     = spc_pkg::FM_MPATH_RST;
    phase         = spc_pkg::PH_ABSENT;
    passes        = 2'd0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // the last three columns are the typed expectation, used where the fixed flag before them is set
    add_row(spc_pkg::REQ_POLL,  1, 0,     0, 0,   0,   0,     0,
            1, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_START, 1, 0,     1, 0,   0,   0,     1,
            1, spc_pkg::PH_INIT,   0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 0,     1, 0,   0,   0,     1,
            1, spc_pkg::PH_SETTLE, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 0,     1, 0,   0,   0,     1,
            1, spc_pkg::PH_LEVEL,  0, spc_pkg::HINT_LEVEL_SETTLE);
    add_row(spc_pkg::REQ_POLL,  1, 200,   1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 1200,  1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 0,     1, 29,  29,  -99,   1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, -2048, 0, 127, 127, -2048, 0,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_START, 0, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 299,   1, 0,   0,   0,     1,
            1, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_START, 0, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 2047,  1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 300,   1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    // band switch to FM with two passes already banked
    add_row(spc_pkg::REQ_POLL,  1, 200,   1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  0, 0,     1, 0,   0,   -2048, 1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_START, 1, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 0,     1, 0,   0,   0,     1,
            0, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    add_row(spc_pkg::REQ_POLL,  1, 1200,  0, 0,   0,   0,     1,
            1, spc_pkg::PH_ABSENT, 0, spc_pkg::HINT_NONE);
    foreach (plan[i]) send_beat(plan[i].s, plan[i].fixed, plan[i].want);

    for (int p = 1; p <= NUM_PHASES; p++) begin
      drain();
      case (p)
        1: begin
          set_reg(spc_pkg::REG_HIGH_SENS, 1);
          set_reg(REG_SPARE, 32'hFFFF_FFFF);
        end
        2: write_all(0, -200, -200, -200, -200, 0, 0);
        3: write_all(1, 1200, 1200, 1200, 1200, 100, 100);
        4: write_all($urandom_range(0, 1),
                     int'($urandom_range(0, 1400)) - 200, int'($urandom_range(0, 1400)) - 200,
                     int'($urandom_range(0, 1400)) - 200, int'($urandom_range(0, 1400)) - 200,
                     $urandom_range(0, 100), $urandom_range(0, 100));
        5: write_all(0, -2048, 2047, 2047, -2048, 127, 127);
        default: write_all(1, $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom());
      endcase
      repeat (PHASE_BEATS) send_beat(draw_beat(), 1'b0, no_fixed);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && presence_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
